>>> sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; expects aclk and aresetn in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define QTS_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("qts assertion failed");

// checked at every edge, reset included
`define QTS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("qts assertion failed");

`endif

>>> sv/qts_pkg.sv
// types, constants and helpers for the quintic trajectory sampler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qts_pkg;

    localparam int VALUE_W    = 32;
    localparam int TIME_W     = 28;
    localparam int PHASE_W    = 17;
    localparam int PHASE_FRAC = 16;
    localparam int TIME_FRAC  = 16;
    localparam int COEF_GUARD = 33;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC;
    localparam int ROUND_HALF = 1 << (PHASE_FRAC - 1);

    localparam int ACC_W   = 3 * VALUE_W + 16;
    localparam int LIMB_W  = 28;
    localparam int NLIMB   = (ACC_W + LIMB_W - 1) / LIMB_W;
    localparam int XW      = NLIMB * LIMB_W;
    localparam int PP_W    = LIMB_W + PHASE_W + 2;
    localparam int PROD_W  = XW + PHASE_W + 1;
    localparam int DIV_W   = 2 * TIME_W + 1;
    localparam int POSQ_W  = ACC_W - COEF_GUARD + 1;

    localparam int NLANE    = 3;
    localparam int NSTEP    = 5;
    localparam int LANE_POS = 0;
    localparam int LANE_VEL = 1;
    localparam int LANE_ACC = 2;

    localparam int NDIV    = 2;
    localparam int DIV_VEL = 0;
    localparam int DIV_ACC = 1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] start_position;
        logic signed [VALUE_W-1:0] start_velocity;
        logic signed [VALUE_W-1:0] start_accel;
        logic signed [VALUE_W-1:0] end_position;
        logic signed [VALUE_W-1:0] end_velocity;
        logic signed [VALUE_W-1:0] end_accel;
        logic [TIME_W-1:0]         segment_time;
        logic [PHASE_W-1:0]        phase;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] position_out;
        logic signed [VALUE_W-1:0] velocity_out;
        logic signed [VALUE_W-1:0] accel_out;
        logic                      saturated;
    } out_t;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic [PHASE_W-1:0]              u;
        logic [DIV_W-1:0]                d_vel;
        logic [DIV_W-1:0]                d_acc;
        acc_t [NLANE-1:0]                acc;
        acc_t [NLANE-1:0][NSTEP-1:0]     coef;
    } horner_t;

    typedef struct packed {
        logic [ACC_W-1:0]   rem;
        logic [ACC_W-1:0]   dsh;
        logic [DIV_W-1:0]   d;
        logic [VALUE_W-1:0] q;
        logic               neg;
        logic               ovf;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [NDIV-1:0] lane;
        logic                 pos_neg;
        logic                 pos_ovf;
        logic [VALUE_W:0]     pos_mag;
    } div_t;

    typedef struct packed {
        logic               clip;
        logic [VALUE_W-1:0] value;
    } sat_t;

    function automatic sat_t sat_value(input logic neg, input logic ovf,
                                       input logic [VALUE_W:0] mag);
        sat_t r;
        logic [VALUE_W:0] half;
        half = {2'b01, {(VALUE_W-1){1'b0}}};
        if (neg) begin
            if (ovf || mag > half) begin
                r.clip  = 1'b1;
                r.value = half[VALUE_W-1:0];
            end else begin
                r.clip  = 1'b0;
                r.value = (~mag[VALUE_W-1:0]) + VALUE_W'(1);
            end
        end else begin
            if (ovf || mag >= half) begin
                r.clip  = 1'b1;
                r.value = {1'b0, {(VALUE_W-1){1'b1}}};
            end else begin
                r.clip  = 1'b0;
                r.value = mag[VALUE_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/quintic_trajectory_sampler.sv
// Quintic trajectory sampler: one result per request, one request per cycle.
// The pipeline has 6 coefficient stages, 5 Horner cells of 2 stages,
// 2 sign/overflow stages, a 32-cell restoring divider chain, a rounding stage
// and the output register. The whole chain advances together whenever the
// output register is empty or being taken, so s_ready drops only in reset or
// while a result sits unaccepted in the output register. No state is carried.
// depends on qts_pkg, qts_coef, qts_horner_cell, qts_div_cell
`timescale 1ns / 1ps
`default_nettype none

module quintic_trajectory_sampler import qts_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    logic en;
    logic m_valid_reg;
    out_t m_payload_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = aresetn && en;

    // coefficient front end
    logic    h_valid [NSTEP+1];
    horner_t h_data  [NSTEP+1];

    qts_coef u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && s_ready),
        .in_data   (s_payload),
        .out_valid (h_valid[0]),
        .out_data  (h_data[0])
    );

    // horner chain
    for (genvar g = 0; g < NSTEP; g++) begin : g_horner
        qts_horner_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (h_valid[g]),
            .in_data   (h_data[g]),
            .out_valid (h_valid[g+1]),
            .out_data  (h_data[g+1])
        );
    end

    // r1: sign and magnitude
    logic             r1_valid_reg;
    logic             r1_neg_reg [NLANE];
    logic [ACC_W-1:0] r1_mag_reg [NLANE];
    logic [DIV_W-1:0] r1_dvel_reg, r1_dacc_reg;
    logic             neg_next [NLANE];
    logic [ACC_W-1:0] mag_next [NLANE];

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            neg_next[l] = h_data[NSTEP].acc[l][ACC_W-1];
            mag_next[l] = neg_next[l] ? (~h_data[NSTEP].acc[l] + ACC_W'(1))
                                      : h_data[NSTEP].acc[l];
        end
    end

    // r2: divider setup, overflow precheck, position rounding
    logic r2_valid_reg;
    div_t r2_data_reg;
    div_t r2_next;

    always_comb begin
        logic [POSQ_W-1:0] pq;
        r2_next = '0;
        r2_next.lane[DIV_VEL].rem = r1_mag_reg[LANE_VEL];
        r2_next.lane[DIV_VEL].d   = r1_dvel_reg;
        r2_next.lane[DIV_VEL].dsh = ACC_W'(r1_dvel_reg) << (VALUE_W - 1);
        r2_next.lane[DIV_VEL].neg = r1_neg_reg[LANE_VEL];
        r2_next.lane[DIV_VEL].ovf = {1'b0, r1_mag_reg[LANE_VEL]}
                                    >= ((ACC_W+1)'(r1_dvel_reg) << VALUE_W);
        r2_next.lane[DIV_ACC].rem = r1_mag_reg[LANE_ACC];
        r2_next.lane[DIV_ACC].d   = r1_dacc_reg;
        r2_next.lane[DIV_ACC].dsh = ACC_W'(r1_dacc_reg) << (VALUE_W - 1);
        r2_next.lane[DIV_ACC].neg = r1_neg_reg[LANE_ACC];
        r2_next.lane[DIV_ACC].ovf = {1'b0, r1_mag_reg[LANE_ACC]}
                                    >= ((ACC_W+1)'(r1_dacc_reg) << VALUE_W);
        pq = POSQ_W'(r1_mag_reg[LANE_POS] >> COEF_GUARD)
           + POSQ_W'(r1_mag_reg[LANE_POS][COEF_GUARD-1]);
        r2_next.pos_neg = r1_neg_reg[LANE_POS];
        r2_next.pos_ovf = |pq[POSQ_W-1:VALUE_W+1];
        r2_next.pos_mag = pq[VALUE_W:0];
    end

    // divider chain
    logic d_valid [VALUE_W+1];
    div_t d_data  [VALUE_W+1];

    assign d_valid[0] = r2_valid_reg;
    assign d_data[0]  = r2_data_reg;

    for (genvar g = 0; g < VALUE_W; g++) begin : g_div
        qts_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (d_valid[g]),
            .in_data   (d_data[g]),
            .out_valid (d_valid[g+1]),
            .out_data  (d_data[g+1])
        );
    end

    // f1: round to nearest, ties away from zero
    logic             f1_valid_reg;
    logic [VALUE_W:0] f1_qr_reg  [NDIV];
    logic             f1_neg_reg [NDIV];
    logic             f1_ovf_reg [NDIV];
    logic             f1_pneg_reg, f1_povf_reg;
    logic [VALUE_W:0] f1_pmag_reg;
    logic [VALUE_W:0] qr_next [NDIV];

    always_comb begin
        logic rnd;
        for (int k = 0; k < NDIV; k++) begin
            rnd = (d_data[VALUE_W].lane[k].rem << 1) >= ACC_W'(d_data[VALUE_W].lane[k].d);
            qr_next[k] = (VALUE_W+1)'(d_data[VALUE_W].lane[k].q) + (VALUE_W+1)'(rnd);
        end
    end

    // output register with saturation
    out_t out_next;

    always_comb begin
        sat_t sp, sv, sa;
        sp = sat_value(f1_pneg_reg, f1_povf_reg, f1_pmag_reg);
        sv = sat_value(f1_neg_reg[DIV_VEL], f1_ovf_reg[DIV_VEL], f1_qr_reg[DIV_VEL]);
        sa = sat_value(f1_neg_reg[DIV_ACC], f1_ovf_reg[DIV_ACC], f1_qr_reg[DIV_ACC]);
        out_next.position_out = sp.value;
        out_next.velocity_out = sv.value;
        out_next.accel_out    = sa.value;
        out_next.saturated    = sp.clip || sv.clip || sa.clip;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            r1_valid_reg <= h_valid[NSTEP];
            r2_valid_reg <= r1_valid_reg;
            f1_valid_reg <= d_valid[VALUE_W];
            m_valid_reg  <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_neg_reg    <= neg_next;
            r1_mag_reg    <= mag_next;
            r1_dvel_reg   <= h_data[NSTEP].d_vel;
            r1_dacc_reg   <= h_data[NSTEP].d_acc;
            r2_data_reg   <= r2_next;
            for (int k = 0; k < NDIV; k++) begin
                f1_qr_reg[k]  <= qr_next[k];
                f1_neg_reg[k] <= d_data[VALUE_W].lane[k].neg;
                f1_ovf_reg[k] <= d_data[VALUE_W].lane[k].ovf;
            end
            f1_pneg_reg   <= d_data[VALUE_W].pos_neg;
            f1_povf_reg   <= d_data[VALUE_W].pos_ovf;
            f1_pmag_reg   <= d_data[VALUE_W].pos_mag;
            m_payload_reg <= out_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire

>>> sv/qts_coef.sv
// coefficient front end: boundary conditions to scaled quintic coefficients
// depends on qts_pkg
`timescale 1ns / 1ps
`default_nettype none

module qts_coef import qts_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    in_valid,
    input  in_t     in_data,
    output logic    out_valid,
    output horner_t out_data
);

    localparam int VT_W = VALUE_W + TIME_W + 1;

    typedef struct packed {
        logic [PHASE_W-1:0] u;
        logic [DIV_W-1:0]   d_vel;
        logic [DIV_W-1:0]   d_acc;
    } side_t;

    // stage 1: clamp, velocity times duration, duration squared
    logic                      s1_valid_reg;
    logic signed [VALUE_W-1:0] s1_p0_reg, s1_a0_reg, s1_p1_reg, s1_a1_reg;
    logic signed [VT_W-1:0]    s1_vt0_reg, s1_vt1_reg;
    logic [2*TIME_W-1:0]       s1_tt_reg;
    logic [TIME_W-1:0]         s1_t_reg;
    logic [PHASE_W-1:0]        s1_u_reg;

    logic [TIME_W-1:0]         t_fix;
    logic [PHASE_W-1:0]        u_fix;
    logic signed [VT_W-1:0]    vt0_next, vt1_next;
    logic [2*TIME_W-1:0]       tt_next;

    always_comb begin
        t_fix = (in_data.segment_time == '0) ? TIME_W'(1) : in_data.segment_time;
        u_fix = (in_data.phase > PHASE_ONE) ? PHASE_ONE : in_data.phase;
        vt0_next = $signed(in_data.start_velocity) * $signed({1'b0, t_fix});
        vt1_next = $signed(in_data.end_velocity) * $signed({1'b0, t_fix});
        tt_next  = t_fix * t_fix;
    end

    // stage 2: accel times duration squared, split in halves
    logic                      s2_valid_reg;
    logic signed [VALUE_W-1:0] s2_p0_reg, s2_p1_reg;
    logic signed [VT_W-1:0]    s2_vt0_reg, s2_vt1_reg;
    logic signed [VT_W-1:0]    s2_a0lo_reg, s2_a0hi_reg, s2_a1lo_reg, s2_a1hi_reg;
    side_t                     s2_side_reg;

    logic signed [VT_W-1:0]    a0lo_next, a0hi_next, a1lo_next, a1hi_next;
    side_t                     side_next;

    always_comb begin
        a0lo_next = $signed(s1_a0_reg) * $signed({1'b0, s1_tt_reg[TIME_W-1:0]});
        a0hi_next = $signed(s1_a0_reg) * $signed({1'b0, s1_tt_reg[2*TIME_W-1:TIME_W]});
        a1lo_next = $signed(s1_a1_reg) * $signed({1'b0, s1_tt_reg[TIME_W-1:0]});
        a1hi_next = $signed(s1_a1_reg) * $signed({1'b0, s1_tt_reg[2*TIME_W-1:TIME_W]});
        side_next.u     = s1_u_reg;
        side_next.d_vel = DIV_W'(s1_t_reg) << (COEF_GUARD - TIME_FRAC);
        side_next.d_acc = DIV_W'(s1_tt_reg) << (COEF_GUARD - 2 * TIME_FRAC);
    end

    // stage 3: align to the coefficient scale
    logic  s3_valid_reg;
    acc_t  s3_c0_reg, s3_c1_reg, s3_c2_reg, s3_p1_reg, s3_v1_reg, s3_a1_reg;
    side_t s3_side_reg;

    acc_t  c0_3, c1_3, c2_3, p1_3, v1_3, a1_3;

    always_comb begin
        c0_3 = ACC_W'(s2_p0_reg) <<< COEF_GUARD;
        p1_3 = ACC_W'(s2_p1_reg) <<< COEF_GUARD;
        c1_3 = ACC_W'(s2_vt0_reg) <<< (COEF_GUARD - TIME_FRAC);
        v1_3 = ACC_W'(s2_vt1_reg) <<< (COEF_GUARD - TIME_FRAC);
        c2_3 = (ACC_W'(s2_a0hi_reg) <<< TIME_W) + ACC_W'(s2_a0lo_reg);
        a1_3 = (ACC_W'(s2_a1hi_reg) <<< TIME_W) + ACC_W'(s2_a1lo_reg);
    end

    // stage 4: end point residuals
    logic  s4_valid_reg;
    acc_t  s4_c0_reg, s4_c1_reg, s4_c2_reg, s4_dp_reg, s4_dv_reg, s4_h_reg;
    side_t s4_side_reg;

    acc_t  dp_4, dv_4, h_4;

    always_comb begin
        dp_4 = s3_p1_reg - s3_c0_reg - s3_c1_reg - s3_c2_reg;
        dv_4 = s3_v1_reg - s3_c1_reg - (s3_c2_reg <<< 1);
        h_4  = s3_a1_reg - s3_c2_reg;
    end

    // stage 5: upper coefficients
    logic  s5_valid_reg;
    acc_t  s5_c0_reg, s5_c1_reg, s5_c2_reg, s5_c3_reg, s5_c4_reg, s5_c5_reg;
    side_t s5_side_reg;

    acc_t  c3_5, c4_5, c5_5;

    always_comb begin
        c3_5 = (s4_dp_reg <<< 3) + (s4_dp_reg <<< 1) - (s4_dv_reg <<< 2) + s4_h_reg;
        c4_5 = s4_dp_reg - (s4_dp_reg <<< 4) + (s4_dv_reg <<< 3) - s4_dv_reg
             - (s4_h_reg <<< 1);
        c5_5 = (s4_dp_reg <<< 2) + (s4_dp_reg <<< 1) - (s4_dv_reg <<< 1) - s4_dv_reg
             + s4_h_reg;
    end

    // stage 6: per lane coefficient queues with derivative weights
    logic    s6_valid_reg;
    horner_t s6_data_reg;
    horner_t h_next;

    always_comb begin
        h_next.u     = s5_side_reg.u;
        h_next.d_vel = s5_side_reg.d_vel;
        h_next.d_acc = s5_side_reg.d_acc;

        h_next.acc[LANE_POS] = s5_c5_reg;
        h_next.acc[LANE_VEL] = '0;
        h_next.acc[LANE_ACC] = '0;

        h_next.coef[LANE_POS][0] = s5_c4_reg;
        h_next.coef[LANE_POS][1] = s5_c3_reg;
        h_next.coef[LANE_POS][2] = s5_c2_reg;
        h_next.coef[LANE_POS][3] = s5_c1_reg;
        h_next.coef[LANE_POS][4] = s5_c0_reg;

        h_next.coef[LANE_VEL][0] = (s5_c5_reg <<< 2) + s5_c5_reg;
        h_next.coef[LANE_VEL][1] = s5_c4_reg <<< 2;
        h_next.coef[LANE_VEL][2] = (s5_c3_reg <<< 1) + s5_c3_reg;
        h_next.coef[LANE_VEL][3] = s5_c2_reg <<< 1;
        h_next.coef[LANE_VEL][4] = s5_c1_reg;

        h_next.coef[LANE_ACC][0] = '0;
        h_next.coef[LANE_ACC][1] = (s5_c5_reg <<< 4) + (s5_c5_reg <<< 2);
        h_next.coef[LANE_ACC][2] = (s5_c4_reg <<< 3) + (s5_c4_reg <<< 2);
        h_next.coef[LANE_ACC][3] = (s5_c3_reg <<< 2) + (s5_c3_reg <<< 1);
        h_next.coef[LANE_ACC][4] = s5_c2_reg <<< 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_p0_reg   <= in_data.start_position;
            s1_a0_reg   <= in_data.start_accel;
            s1_p1_reg   <= in_data.end_position;
            s1_a1_reg   <= in_data.end_accel;
            s1_vt0_reg  <= vt0_next;
            s1_vt1_reg  <= vt1_next;
            s1_tt_reg   <= tt_next;
            s1_t_reg    <= t_fix;
            s1_u_reg    <= u_fix;

            s2_p0_reg   <= s1_p0_reg;
            s2_p1_reg   <= s1_p1_reg;
            s2_vt0_reg  <= s1_vt0_reg;
            s2_vt1_reg  <= s1_vt1_reg;
            s2_a0lo_reg <= a0lo_next;
            s2_a0hi_reg <= a0hi_next;
            s2_a1lo_reg <= a1lo_next;
            s2_a1hi_reg <= a1hi_next;
            s2_side_reg <= side_next;

            s3_c0_reg   <= c0_3;
            s3_c1_reg   <= c1_3;
            s3_c2_reg   <= c2_3;
            s3_p1_reg   <= p1_3;
            s3_v1_reg   <= v1_3;
            s3_a1_reg   <= a1_3;
            s3_side_reg <= s2_side_reg;

            s4_c0_reg   <= s3_c0_reg;
            s4_c1_reg   <= s3_c1_reg;
            s4_c2_reg   <= s3_c2_reg;
            s4_dp_reg   <= dp_4;
            s4_dv_reg   <= dv_4;
            s4_h_reg    <= h_4;
            s4_side_reg <= s3_side_reg;

            s5_c0_reg   <= s4_c0_reg;
            s5_c1_reg   <= s4_c1_reg;
            s5_c2_reg   <= s4_c2_reg;
            s5_c3_reg   <= c3_5;
            s5_c4_reg   <= c4_5;
            s5_c5_reg   <= c5_5;
            s5_side_reg <= s4_side_reg;

            s6_data_reg <= h_next;
        end
    end

    assign out_valid = s6_valid_reg;
    assign out_data  = s6_data_reg;

endmodule

`default_nettype wire

>>> sv/qts_horner_cell.sv
// one horner step for the three lanes: acc = round(acc * u) + next coefficient
// depends on qts_pkg
`timescale 1ns / 1ps
`default_nettype none

module qts_horner_cell import qts_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    in_valid,
    input  horner_t in_data,
    output logic    out_valid,
    output horner_t out_data
);

    // stage a: limb partial products
    logic              a_valid_reg;
    horner_t           a_data_reg;
    logic signed [PP_W-1:0] a_pp_reg [NLANE][NLIMB];
    logic signed [PP_W-1:0] pp_next  [NLANE][NLIMB];

    always_comb begin
        logic signed [XW-1:0] ax;
        logic [LIMB_W-1:0]    limb;
        for (int l = 0; l < NLANE; l++) begin
            ax = XW'($signed(in_data.acc[l]));
            for (int i = 0; i < NLIMB; i++) begin
                limb = ax[i*LIMB_W +: LIMB_W];
                if (i == NLIMB - 1) begin
                    pp_next[l][i] = $signed(limb) * $signed({1'b0, in_data.u});
                end else begin
                    pp_next[l][i] = $signed({1'b0, limb}) * $signed({1'b0, in_data.u});
                end
            end
        end
    end

    // stage b: sum, round half up, add coefficient, advance the queue
    logic    b_valid_reg;
    horner_t b_data_reg;
    horner_t b_next;

    always_comb begin
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] rnd;
        b_next = a_data_reg;
        for (int l = 0; l < NLANE; l++) begin
            prod = '0;
            for (int i = 0; i < NLIMB; i++) begin
                prod = prod + (PROD_W'(a_pp_reg[l][i]) <<< (i * LIMB_W));
            end
            rnd = (prod + PROD_W'(ROUND_HALF)) >>> PHASE_FRAC;
            b_next.acc[l] = ACC_W'(rnd) + $signed(a_data_reg.coef[l][0]);
            for (int j = 0; j < NSTEP - 1; j++) begin
                b_next.coef[l][j] = a_data_reg.coef[l][j+1];
            end
            b_next.coef[l][NSTEP-1] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_data_reg <= in_data;
            a_pp_reg   <= pp_next;
            b_data_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

>>> sv/qts_div_cell.sv
// one restoring division step for the velocity and acceleration lanes
// depends on qts_pkg
`timescale 1ns / 1ps
`default_nettype none

module qts_div_cell import qts_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    always_comb begin
        logic take;
        data_next = in_data;
        for (int k = 0; k < NDIV; k++) begin
            take = (in_data.lane[k].rem >= in_data.lane[k].dsh);
            if (take) begin
                data_next.lane[k].rem = in_data.lane[k].rem - in_data.lane[k].dsh;
            end
            data_next.lane[k].q   = {in_data.lane[k].q[VALUE_W-2:0], take};
            data_next.lane[k].dsh = in_data.lane[k].dsh >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> sv/qts_checker.sv
// port-level checks for the quintic trajectory sampler, bound to the top level
// depends on qts_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module qts_checker import qts_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_payload
);

    localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // some output sits at a range limit
    logic at_limit;

    assign at_limit = (m_payload.position_out == VMAX) || (m_payload.position_out == VMIN)
                   || (m_payload.velocity_out == VMAX) || (m_payload.velocity_out == VMIN)
                   || (m_payload.accel_out == VMAX) || (m_payload.accel_out == VMIN);

    `QTS_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid)
    `QTS_ASSERT(a_ready_tracks_out, s_ready == (!m_valid || m_ready))
    `QTS_ASSERT(a_sat_at_limit, m_valid && m_payload.saturated |-> at_limit)
    `QTS_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_payload))

endmodule

bind quintic_trajectory_sampler qts_checker u_qts_checker (.*);

`default_nettype wire
